// ===== src/srecord_hex_emitter_defines.svh =====
// assertion macros for the s-record emitter
`ifndef SRECORD_HEX_EMITTER_DEFINES_SVH
`define SRECORD_HEX_EMITTER_DEFINES_SVH

`ifndef SYNTH
`define SRHE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srecord emitter: same-cycle check failed");
`define SRHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srecord emitter: next-cycle check failed");
`else
`define SRHE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SRHE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/srhe_pkg.sv =====
package srhe_pkg;

    localparam int unsigned RECORD_BYTES_DEF = 16;

    localparam logic [1:0] FUNC_DATA   = 2'd0;
    localparam logic [1:0] FUNC_SEG    = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] S9_COUNT   = 8'h03;
    localparam logic [7:0] S1_EXTRA   = 8'h03;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic [15:0] seg_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S1_HEAD,
        ST_S1_DATA,
        ST_S1_TAIL,
        ST_S9
    } t_state;

    typedef enum logic [3:0] {
        SEL_S,
        SEL_ONE,
        SEL_NINE,
        SEL_NEWLINE,
        SEL_CNT,
        SEL_AHI,
        SEL_ALO,
        SEL_DATA,
        SEL_SUM,
        SEL_S9_CNT,
        SEL_NHI,
        SEL_NLO,
        SEL_NSUM
    } t_char_sel;

    typedef struct packed {
        logic      emit;
        t_char_sel sel;
        logic      nib_hi;
        logic      last;
        logic      clear_fill;
    } t_ctl_cmd;

    typedef struct packed {
        logic slot_free;
        logic fill_zero;
    } t_dp_sts;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        if (v < 4'd10) begin
            hex_char = 8'h30 + w;
        end else begin
            hex_char = 8'h37 + w;
        end
    endfunction

endpackage

// ===== src/srecord_hex_emitter.sv =====
// s19 text emitter for a 16-bit memory image
// input channel: i_in_valid / o_in_stall carrying i_in_item (func, data_byte,
// seg_address); output channel: o_out_valid / i_out_stall carrying one ascii
// character per beat with last_char set on the final character of an item
// an item is taken only while no record is being written out; a data beat
// that does not fill the record buffer is only stored and gives no output
// the beat that fills the buffer, or a begin-segment / finish beat with data
// pending, starts an s1 record of 2*n+11 characters, one per cycle unless the
// receiver stalls; finish adds an s9 record of 11 characters
// the accepting edge sets the control state and the first character is then
// registered; the rest follow one per cycle unless the receiver stalls
// the next item is taken the cycle after the last character is registered
// the single output register sets the pace: while the receiver stalls, the
// character generator holds and no input is taken until the record is out
// reset clears the fill count, both addresses and the output valid; the
// record buffer needs no clearing since only bytes written are read
module srecord_hex_emitter #(
    parameter int unsigned RECORD_BYTES = srhe_pkg::RECORD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  srhe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output srhe_pkg::t_out_item o_out_item
);
    import srhe_pkg::*;

    localparam int unsigned FW = $clog2(RECORD_BYTES + 1);
    localparam int unsigned IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    logic          w_busy;
    logic          w_accept;
    t_ctl_cmd      w_cmd;
    t_dp_sts       w_sts;
    logic [FW-1:0] w_fill;
    logic [IW-1:0] w_rd_index;

    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;

    srhe_ctrl #(
        .RECORD_BYTES (RECORD_BYTES),
        .FW           (FW),
        .IW           (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_func     (i_in_item.func),
        .i_sts      (w_sts),
        .i_fill     (w_fill),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd),
        .o_rd_index (w_rd_index)
    );

    srhe_dpath #(
        .RECORD_BYTES (RECORD_BYTES),
        .FW           (FW),
        .IW           (IW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .i_cmd       (w_cmd),
        .i_rd_index  (w_rd_index),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_fill      (w_fill),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== src/srhe_ctrl.sv =====
`include "srecord_hex_emitter_defines.svh"

module srhe_ctrl #(
    parameter int unsigned RECORD_BYTES = srhe_pkg::RECORD_BYTES_DEF,
    parameter int unsigned FW = $clog2(RECORD_BYTES + 1),
    parameter int unsigned IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_func,
    input  srhe_pkg::t_dp_sts  i_sts,
    input  logic [FW-1:0]      i_fill,
    output logic               o_busy,
    output srhe_pkg::t_ctl_cmd o_cmd,
    output logic [IW-1:0]      o_rd_index
);
    import srhe_pkg::*;

    localparam int unsigned PW_DATA = $clog2(2 * RECORD_BYTES);
    localparam int unsigned PW = (PW_DATA > 4) ? PW_DATA : 4;

    t_state        r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_then_s9, n_then_s9;
    logic [PW-1:0] w_data_end;
    logic          w_full_next;
    t_ctl_cmd      w_cmd;

    assign w_data_end  = PW'({i_fill, 1'b0}) - PW'(1);
    assign w_full_next = (i_fill == FW'(RECORD_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_then_s9 <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_then_s9 <= n_then_s9;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_then_s9 = r_then_s9;
        case (r_state)
            ST_IDLE: begin
                n_pos = '0;
                if (i_accept) begin
                    case (i_func)
                        FUNC_DATA: begin
                            n_then_s9 = 1'b0;
                            if (w_full_next) begin
                                n_state = ST_S1_HEAD;
                            end
                        end
                        FUNC_SEG: begin
                            n_then_s9 = 1'b0;
                            if (!i_sts.fill_zero) begin
                                n_state = ST_S1_HEAD;
                            end
                        end
                        FUNC_FINISH: begin
                            n_then_s9 = 1'b1;
                            n_state   = i_sts.fill_zero ? ST_S9 : ST_S1_HEAD;
                        end
                        default: begin
                            n_then_s9 = 1'b0;
                        end
                    endcase
                end
            end
            ST_S1_HEAD: begin
                if (i_sts.slot_free) begin
                    n_pos = r_pos + PW'(1);
                    if (r_pos == PW'(7)) begin
                        n_pos   = '0;
                        n_state = ST_S1_DATA;
                    end
                end
            end
            ST_S1_DATA: begin
                if (i_sts.slot_free) begin
                    n_pos = r_pos + PW'(1);
                    if (r_pos == w_data_end) begin
                        n_pos   = '0;
                        n_state = ST_S1_TAIL;
                    end
                end
            end
            ST_S1_TAIL: begin
                if (i_sts.slot_free) begin
                    n_pos = r_pos + PW'(1);
                    if (r_pos == PW'(2)) begin
                        n_pos   = '0;
                        n_state = r_then_s9 ? ST_S9 : ST_IDLE;
                    end
                end
            end
            ST_S9: begin
                if (i_sts.slot_free) begin
                    n_pos = r_pos + PW'(1);
                    if (r_pos == PW'(10)) begin
                        n_pos   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_pos   = '0;
            end
        endcase
    end

    // command decode
    always_comb begin
        w_cmd            = '0;
        w_cmd.sel        = SEL_S;
        w_cmd.nib_hi     = !r_pos[0];
        w_cmd.emit       = (r_state != ST_IDLE) && i_sts.slot_free;
        case (r_state)
            ST_S1_HEAD: begin
                case (r_pos[2:1])
                    2'd0:    w_cmd.sel = r_pos[0] ? SEL_ONE : SEL_S;
                    2'd1:    w_cmd.sel = SEL_CNT;
                    2'd2:    w_cmd.sel = SEL_AHI;
                    default: w_cmd.sel = SEL_ALO;
                endcase
            end
            ST_S1_DATA: begin
                w_cmd.sel = SEL_DATA;
            end
            ST_S1_TAIL: begin
                if (r_pos[1]) begin
                    w_cmd.sel        = SEL_NEWLINE;
                    w_cmd.last       = !r_then_s9;
                    w_cmd.clear_fill = w_cmd.emit;
                end else begin
                    w_cmd.sel = SEL_SUM;
                end
            end
            ST_S9: begin
                case (r_pos[3:1])
                    3'd0:    w_cmd.sel = r_pos[0] ? SEL_NINE : SEL_S;
                    3'd1:    w_cmd.sel = SEL_S9_CNT;
                    3'd2:    w_cmd.sel = SEL_NHI;
                    3'd3:    w_cmd.sel = SEL_NLO;
                    3'd4:    w_cmd.sel = SEL_NSUM;
                    default: begin
                        w_cmd.sel  = SEL_NEWLINE;
                        w_cmd.last = 1'b1;
                    end
                endcase
            end
            default: begin
                w_cmd.emit = 1'b0;
            end
        endcase
    end

    // buffer read is registered, so address the byte of the next position
    assign o_cmd      = w_cmd;
    assign o_busy     = (r_state != ST_IDLE);
    assign o_rd_index = n_pos[IW:1];

    `SRHE_ASSERT_SAME(a_idle_quiet, i_clk, i_rst_n, r_state == ST_IDLE, !w_cmd.emit)
    `SRHE_ASSERT_SAME(a_emit_slot, i_clk, i_rst_n, w_cmd.emit, i_sts.slot_free)
    `SRHE_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_cmd.emit && w_cmd.last,
                      r_state == ST_IDLE)
    `SRHE_ASSERT_SAME(a_data_filled, i_clk, i_rst_n, r_state == ST_S1_DATA,
                      !i_sts.fill_zero)

endmodule

// ===== src/srhe_dpath.sv =====
module srhe_dpath #(
    parameter int unsigned RECORD_BYTES = srhe_pkg::RECORD_BYTES_DEF,
    parameter int unsigned FW = $clog2(RECORD_BYTES + 1),
    parameter int unsigned IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  srhe_pkg::t_in_item  i_item,
    input  srhe_pkg::t_ctl_cmd  i_cmd,
    input  logic [IW-1:0]       i_rd_index,
    input  logic                i_out_stall,
    output srhe_pkg::t_dp_sts   o_sts,
    output logic [FW-1:0]       o_fill,
    output logic                o_out_valid,
    output srhe_pkg::t_out_item o_out_item
);
    import srhe_pkg::*;

    logic [7:0]  r_buf [RECORD_BYTES];
    logic [7:0]  r_rd_byte;
    logic [FW-1:0] r_fill;
    logic [15:0] r_rec_addr;
    logic [15:0] r_next_addr;
    logic [7:0]  r_dsum;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_fill_zero;
    logic        w_slot_free;
    logic        w_store;
    logic [7:0]  w_cnt;
    logic [7:0]  w_byte;
    logic [3:0]  w_nib;
    logic [7:0]  w_char;

    assign w_fill_zero = (r_fill == '0);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_store     = i_accept && (i_item.func == FUNC_DATA);
    assign w_cnt       = 8'(r_fill) + S1_EXTRA;

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_buf[r_fill[IW-1:0]] <= i_item.data_byte;
        end
        r_rd_byte <= r_buf[i_rd_index];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rec_addr  <= '0;
            r_next_addr <= '0;
            r_dsum      <= '0;
        end else if (i_accept) begin
            if (i_item.func == FUNC_DATA) begin
                if (w_fill_zero) begin
                    r_rec_addr <= r_next_addr;
                    r_dsum     <= i_item.data_byte;
                end else begin
                    r_dsum <= r_dsum + i_item.data_byte;
                end
                r_fill      <= r_fill + FW'(1);
                r_next_addr <= r_next_addr + 16'd1;
            end else if (i_item.func == FUNC_SEG) begin
                r_next_addr <= i_item.seg_address;
            end
        end else if (i_cmd.clear_fill) begin
            r_fill <= '0;
        end
    end

    // byte behind the current hex pair
    always_comb begin
        case (i_cmd.sel)
            SEL_CNT:    w_byte = w_cnt;
            SEL_AHI:    w_byte = r_rec_addr[15:8];
            SEL_ALO:    w_byte = r_rec_addr[7:0];
            SEL_DATA:   w_byte = r_rd_byte;
            SEL_SUM:    w_byte = ~(w_cnt + r_rec_addr[15:8] + r_rec_addr[7:0] + r_dsum);
            SEL_S9_CNT: w_byte = S9_COUNT;
            SEL_NHI:    w_byte = r_next_addr[15:8];
            SEL_NLO:    w_byte = r_next_addr[7:0];
            SEL_NSUM:   w_byte = ~(S9_COUNT + r_next_addr[15:8] + r_next_addr[7:0]);
            default:    w_byte = 8'h00;
        endcase
        w_nib = i_cmd.nib_hi ? w_byte[7:4] : w_byte[3:0];
        case (i_cmd.sel)
            SEL_S:       w_char = CH_S;
            SEL_ONE:     w_char = CH_ONE;
            SEL_NINE:    w_char = CH_NINE;
            SEL_NEWLINE: w_char = CH_NEWLINE;
            default:     w_char = hex_char(w_nib);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && i_cmd.emit) begin
            r_out.text_char <= w_char;
            r_out.last_char <= i_cmd.last;
        end
    end

    assign o_sts.slot_free = w_slot_free;
    assign o_sts.fill_zero = w_fill_zero;
    assign o_fill          = r_fill;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;

endmodule
